@@ src/edf_ready_queue_scheduler_defines.svh @@
// Assertion macros shared by the EDF ready queue scheduler RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef EDF_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define EDF_READY_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define EDFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define EDFQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EDFQ_ASSERT(lbl, prop, msg)
`define EDFQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/edfq_pkg.sv @@
// Shared types and constants for the EDF ready queue scheduler.
// No dependencies; imported by the cell, the queue chain and the top level.
`default_nettype none

package edfq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 32;
  localparam int ID_BITS   = 4;
  localparam int NUM_IDS   = 1 << ID_BITS;
  localparam int CNT_BITS  = $clog2(MAX_TASKS);

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_SCHEDULE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_MISS     = 3'd1,
    KIND_DISPATCH = 3'd2,
    KIND_IDLE     = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic                 vld;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] key;
  } cell_ent_t;

  typedef struct packed {
    cell_op_t             op;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] key;
    logic [TIME_BITS-1:0] now;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ src/edf_ready_queue_scheduler.sv @@
// Top level of the EDF ready queue scheduler: request sequencer, per-task
// tick counters and result register. Depends on edfq_pkg and edfq_chain.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | mode, task_id, deadline, now, clear_exec
//   out_    | output    | out_valid / out_ready  | kind, task_id_res, task_deadline,
//           |           |                        | exec_ticks, last
//
// A request is taken only while the sequencer is idle. Insert, remove and
// schedule run through ST_INS, ST_REM or ST_HEAD; a tick runs through ST_TICK
// and then ST_HEAD if no entry missed, or else ST_SCAN for one full rotation
// of the cell row that brings each entry to the head once. A result that is
// due waits while the result register is still held. Reset is synchronous
// and leaves the queue empty and all tick counters at zero.
`default_nettype none
`include "edf_ready_queue_scheduler_defines.svh"

module edf_ready_queue_scheduler import edfq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [ID_BITS-1:0]   in_task_id,
  input  logic [TIME_BITS-1:0] in_deadline,
  input  logic [TIME_BITS-1:0] in_now,
  input  logic                 in_clear_exec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [ID_BITS-1:0]   out_task_id_res,
  output logic [TIME_BITS-1:0] out_task_deadline,
  output logic [TIME_BITS-1:0] out_exec_ticks,
  output logic                 out_last
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INS  = 6'b000010,
    ST_REM  = 6'b000100,
    ST_TICK = 6'b001000,
    ST_HEAD = 6'b010000,
    ST_SCAN = 6'b100000
  } state_t;

  localparam logic [TIME_BITS-1:0] TICKS_MAX = {TIME_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]  SCAN_END  = CNT_BITS'(MAX_TASKS - 1);

  state_t state_r, state_nxt;

  // Captured request.
  mode_t                mode_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] key_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 clr_r;

  logic [MAX_TASKS-1:0] mask_r, mask_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic [NUM_IDS-1:0][TIME_BITS-1:0] exec_r;
  logic                 exec_we;
  logic [ID_BITS-1:0]   exec_wa;
  logic [TIME_BITS-1:0] exec_wd;
  logic [ID_BITS-1:0]   exec_ra;
  logic [TIME_BITS-1:0] exec_rd;

  cell_cmd_t            cmd;
  cell_ent_t            head;
  logic                 q_full;
  logic                 q_found;
  logic [TIME_BITS-1:0] q_found_key;
  logic [MAX_TASKS-1:0] q_miss;
  logic [MAX_TASKS-1:0] q_vld;

  logic                 out_valid_r;
  kind_t                out_kind_r, kind_nxt;
  logic [ID_BITS-1:0]   out_id_r, id_nxt;
  logic [TIME_BITS-1:0] out_dl_r, dl_nxt;
  logic [TIME_BITS-1:0] out_ex_r, ex_nxt;
  logic                 out_last_r, last_nxt;
  logic                 load_out;
  logic                 out_free;
  logic                 in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign exec_ra = (state_r == ST_INS || state_r == ST_REM) ? id_r : head.id;
  assign exec_rd = exec_r[exec_ra];

  edfq_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .head      (head),
    .full      (q_full),
    .found     (q_found),
    .found_key (q_found_key),
    .miss_vec  (q_miss),
    .vld_vec   (q_vld)
  );

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    cmd.op    = CELL_HOLD;
    cmd.id    = id_r;
    cmd.key   = key_r;
    cmd.now   = now_r;
    exec_we   = 1'b0;
    exec_wa   = id_r;
    exec_wd   = '0;
    load_out  = 1'b0;
    kind_nxt  = KIND_DONE;
    id_nxt    = id_r;
    dl_nxt    = '0;
    ex_nxt    = '0;
    last_nxt  = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_t'(in_mode))
            MODE_INSERT:   state_nxt = ST_INS;
            MODE_REMOVE:   state_nxt = ST_REM;
            MODE_TICK:     state_nxt = ST_TICK;
            MODE_SCHEDULE: state_nxt = ST_HEAD;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (q_found || q_full) begin
            kind_nxt = KIND_REJECT;
          end else begin
            cmd.op   = CELL_INSERT;
            kind_nxt = KIND_DONE;
            dl_nxt   = key_r;
            ex_nxt   = clr_r ? '0 : exec_rd;
            exec_we  = clr_r;
          end
        end
      end
      ST_REM: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (q_found) begin
            cmd.op   = CELL_REMOVE;
            kind_nxt = KIND_DONE;
            dl_nxt   = q_found_key;
            ex_nxt   = exec_rd;
          end else begin
            kind_nxt = KIND_REJECT;
          end
        end
      end
      ST_TICK: begin
        // The head's counter moves first, so every report below sees it.
        exec_wa  = head.id;
        exec_wd  = exec_rd + TIME_BITS'(1);
        exec_we  = head.vld && (exec_rd != TICKS_MAX);
        mask_nxt = q_miss;
        cnt_nxt  = '0;
        state_nxt = (q_miss == '0) ? ST_HEAD : ST_SCAN;
      end
      ST_HEAD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (mode_r == MODE_TICK) begin
            kind_nxt = KIND_DONE;
          end else if (head.vld) begin
            kind_nxt = KIND_DISPATCH;
          end else begin
            kind_nxt = KIND_IDLE;
          end
          id_nxt = head.vld ? head.id : '0;
          dl_nxt = head.vld ? head.key : '0;
          ex_nxt = head.vld ? exec_rd : '0;
        end
      end
      ST_SCAN: begin
        // One rotation step per cycle; a step that reports waits for room.
        if (!mask_r[0] || out_free) begin
          cmd.op   = CELL_ROTATE;
          mask_nxt = mask_r >> 1;
          cnt_nxt  = cnt_r + CNT_BITS'(1);
          if (mask_r[0]) begin
            load_out = 1'b1;
            kind_nxt = KIND_MISS;
            id_nxt   = head.id;
            dl_nxt   = head.key;
            ex_nxt   = exec_rd;
            last_nxt = (mask_r[MAX_TASKS-1:1] == '0);
          end
          if (cnt_r == SCAN_END) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      exec_r      <= '0;
      mask_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      if (exec_we) begin
        exec_r[exec_wa] <= exec_wd;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_mode);
      id_r   <= in_task_id;
      key_r  <= in_deadline;
      now_r  <= in_now;
      clr_r  <= in_clear_exec;
    end
    if (load_out) begin
      out_kind_r <= kind_nxt;
      out_id_r   <= id_nxt;
      out_dl_r   <= dl_nxt;
      out_ex_r   <= ex_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_task_id_res   = out_id_r;
  assign out_task_deadline = out_dl_r;
  assign out_exec_ticks    = out_ex_r;
  assign out_last          = out_last_r;

  // A full rotation neither adds nor drops queued tasks.
  `EDFQ_ASSERT(a_scan_keeps_count, (state_r == ST_SCAN) |=> ($countones(q_vld) == $past($countones(q_vld))), "scan changed queue size")
  // Tick counters change only on an insert or a tick.
  `EDFQ_ASSERT(a_exec_quiet, (state_r != ST_INS && state_r != ST_TICK) |=> $stable(exec_r), "tick counter changed unexpectedly")

endmodule

`default_nettype wire

@@ src/edfq_cell.sv @@
// One slot of the sorted ready queue: holds a task id and its deadline key.
// Depends on edfq_pkg for the entry and command structs.
`default_nettype none

module edfq_cell import edfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  cell_ent_t left,
  input  logic      left_stay,
  input  cell_ent_t right,
  input  logic      del_in,
  output cell_ent_t ent,
  output logic      stay,
  output logic      del_out,
  output logic      match,
  output logic      miss
);

  cell_ent_t ent_r;
  cell_ent_t ent_nxt;

  assign ent     = ent_r;
  assign stay    = ent_r.vld && (ent_r.key <= cmd.key);
  assign match   = ent_r.vld && (ent_r.id == cmd.id);
  assign del_out = del_in || match;
  assign miss    = ent_r.vld && (ent_r.key < cmd.now);

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      CELL_HOLD: begin
        ent_nxt = ent_r;
      end
      CELL_INSERT: begin
        // Entries with a larger key move one slot right; the new one lands
        // in the first slot whose left neighbor stays.
        if (!stay) begin
          if (left_stay) begin
            ent_nxt.vld = 1'b1;
            ent_nxt.id  = cmd.id;
            ent_nxt.key = cmd.key;
          end else begin
            ent_nxt = left;
          end
        end
      end
      CELL_REMOVE: begin
        if (del_out) begin
          ent_nxt = right;
        end
      end
      CELL_ROTATE: begin
        ent_nxt = right;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/edfq_chain.sv @@
// Row of queue cells kept sorted by deadline, head in cell zero.
// Depends on edfq_pkg and edfq_cell; assertions use the shared macro header.
`default_nettype none
`include "edf_ready_queue_scheduler_defines.svh"

module edfq_chain import edfq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  output cell_ent_t            head,
  output logic                 full,
  output logic                 found,
  output logic [TIME_BITS-1:0] found_key,
  output logic [MAX_TASKS-1:0] miss_vec,
  output logic [MAX_TASKS-1:0] vld_vec
);

  cell_ent_t            ent_a [MAX_TASKS];
  logic [MAX_TASKS-1:0] stay_v;
  logic [MAX_TASKS-1:0] del_v;
  logic [MAX_TASKS-1:0] match_v;
  cell_ent_t            wrap_ent;

  // The last cell refills from the head only while rotating.
  assign wrap_ent = (cmd.op == CELL_ROTATE) ? ent_a[0] : '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    cell_ent_t left_ent;
    cell_ent_t right_ent;
    logic      left_st;
    logic      del_prev;

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_st  = 1'b1;
      assign del_prev = 1'b0;
    end else begin : g_mid
      assign left_ent = ent_a[i-1];
      assign left_st  = stay_v[i-1];
      assign del_prev = del_v[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_ent = wrap_ent;
    end else begin : g_inner
      assign right_ent = ent_a[i+1];
    end

    edfq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left      (left_ent),
      .left_stay (left_st),
      .right     (right_ent),
      .del_in    (del_prev),
      .ent       (ent_a[i]),
      .stay      (stay_v[i]),
      .del_out   (del_v[i]),
      .match     (match_v[i]),
      .miss      (miss_vec[i])
    );

    assign vld_vec[i] = ent_a[i].vld;
  end

  assign head  = ent_a[0];
  assign full  = ent_a[MAX_TASKS-1].vld;
  assign found = del_v[MAX_TASKS-1];

  always_comb begin
    found_key = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      found_key = found_key | (ent_a[i].key & {TIME_BITS{match_v[i]}});
    end
  end

  // A rotation leaves gaps for a while, but whenever an entry is added or
  // removed the occupied cells form one block starting at the head.
  `EDFQ_ASSERT(a_vld_packed, (cmd.op == CELL_INSERT || cmd.op == CELL_REMOVE) |-> (((vld_vec >> 1) & ~vld_vec) == '0), "queue has a hole")
  // A task id sits in at most one cell.
  `EDFQ_ASSERT(a_id_unique, $onehot0(match_v), "task id queued twice")

endmodule

`default_nettype wire

@@ verif/edf_ready_queue_scheduler_test.sv @@
// Self-checking test of the EDF ready queue scheduler: directed and random requests
// are scored against an in-bench copy of the ready queue. Needs edfq_pkg and the RTL.
module edf_ready_queue_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import edfq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    kind_t                kind;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] ticks;
    logic                 last;
  } sched_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_mode;
  logic [ID_BITS-1:0]   in_task_id;
  logic [TIME_BITS-1:0] in_deadline;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_clear_exec;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_kind;
  logic [ID_BITS-1:0]   out_task_id_res;
  logic [TIME_BITS-1:0] out_task_deadline;
  logic [TIME_BITS-1:0] out_exec_ticks;
  logic                 out_last;

  // Bench copy of the ready queue and the per-task tick counters.
  logic [TIME_BITS-1:0] q_keys [MAX_TASKS];
  logic [ID_BITS-1:0]   q_ids [MAX_TASKS];
  int                   q_count;
  logic [NUM_IDS-1:0]   q_present;
  logic [TIME_BITS-1:0] run_ticks [NUM_IDS];

  sched_result_t        pending_results[$];
  int                   mismatches;
  int                   stall_left;
  int                   quiet_cycles;
  bit                   idle_en;
  logic [TIME_BITS-1:0] tick_now;

  edf_ready_queue_scheduler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_task_id        (in_task_id),
    .in_deadline       (in_deadline),
    .in_now            (in_now),
    .in_clear_exec     (in_clear_exec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_task_id_res   (out_task_id_res),
    .out_task_deadline (out_task_deadline),
    .out_exec_ticks    (out_exec_ticks),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic sched_result_t make_result(kind_t k, logic [ID_BITS-1:0] id,
                                                logic [TIME_BITS-1:0] dl,
                                                logic [TIME_BITS-1:0] t, logic l);
    sched_result_t res;
    res.kind     = k;
    res.task_id  = id;
    res.deadline = dl;
    res.ticks    = t;
    res.last     = l;
    return res;
  endfunction

  // Returns an id whose queued state matches want_present, if there is one.
  function automatic logic [ID_BITS-1:0] pick_id(bit want_present);
    int start;
    int k;
    logic [ID_BITS-1:0] idx;
    start = $urandom_range(0, NUM_IDS - 1);
    for (k = 0; k < NUM_IDS; k++) begin
      idx = ID_BITS'((start + k) % NUM_IDS);
      if (q_present[idx] == want_present) return idx;
    end
    return ID_BITS'(start);
  endfunction

  task automatic predict_edf_event(mode_t m, logic [ID_BITS-1:0] id,
                                   logic [TIME_BITS-1:0] dl, logic [TIME_BITS-1:0] nw,
                                   logic clr);
    int pos;
    int i;
    int n_miss;
    int seen;
    logic [ID_BITS-1:0] head;
    logic [TIME_BITS-1:0] key;
    case (m)
      MODE_INSERT: begin
        if (q_present[id] || q_count >= MAX_TASKS) begin
          pending_results.push_back(make_result(KIND_REJECT, id, '0, '0, 1'b1));
        end else begin
          // A new entry goes behind every entry with an equal or smaller key.
          pos = 0;
          while (pos < q_count && q_keys[pos] <= dl) pos++;
          for (i = q_count; i > pos; i--) begin
            q_keys[i] = q_keys[i-1];
            q_ids[i]  = q_ids[i-1];
          end
          q_keys[pos] = dl;
          q_ids[pos]  = id;
          q_count++;
          q_present[id] = 1'b1;
          if (clr) run_ticks[id] = '0;
          pending_results.push_back(make_result(KIND_DONE, id, dl, run_ticks[id], 1'b1));
        end
      end
      MODE_REMOVE: begin
        if (!q_present[id]) begin
          pending_results.push_back(make_result(KIND_REJECT, id, '0, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < q_count && q_ids[pos] != id) pos++;
          key = q_keys[pos];
          for (i = pos; i + 1 < q_count; i++) begin
            q_keys[i] = q_keys[i+1];
            q_ids[i]  = q_ids[i+1];
          end
          q_count--;
          q_present[id] = 1'b0;
          pending_results.push_back(make_result(KIND_DONE, id, key, run_ticks[id], 1'b1));
        end
      end
      MODE_TICK: begin
        if (q_count > 0) begin
          head = q_ids[0];
          if (run_ticks[head] != '1) run_ticks[head] = run_ticks[head] + TIME_BITS'(1);
        end
        n_miss = 0;
        for (i = 0; i < q_count; i++) if (q_keys[i] < nw) n_miss++;
        if (n_miss > 0) begin
          seen = 0;
          for (i = 0; i < q_count; i++) begin
            if (q_keys[i] < nw) begin
              seen++;
              pending_results.push_back(make_result(KIND_MISS, q_ids[i], q_keys[i],
                                                    run_ticks[q_ids[i]], seen == n_miss));
            end
          end
        end else if (q_count > 0) begin
          pending_results.push_back(make_result(KIND_DONE, q_ids[0], q_keys[0],
                                                run_ticks[q_ids[0]], 1'b1));
        end else begin
          pending_results.push_back(make_result(KIND_DONE, '0, '0, '0, 1'b1));
        end
      end
      default: begin
        if (q_count == 0) begin
          pending_results.push_back(make_result(KIND_IDLE, '0, '0, '0, 1'b1));
        end else begin
          pending_results.push_back(make_result(KIND_DISPATCH, q_ids[0], q_keys[0],
                                                run_ticks[q_ids[0]], 1'b1));
        end
      end
    endcase
  endtask

  // Presents one request, holds it until it is taken and then predicts its results.
  task automatic send_event(mode_t m, logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] dl,
                            logic [TIME_BITS-1:0] nw, logic clr);
    int gap;
    gap = (idle_en && $urandom_range(0, 1) == 0) ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_task_id    <= id;
    in_deadline   <= dl;
    in_now        <= nw;
    in_clear_exec <= clr;
    do @(posedge clk); while (!in_ready);
    predict_edf_event(m, id, dl, nw, clr);
  endtask

  task automatic note_mismatch(string what, sched_result_t want, sched_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d id=%0d deadline=%h ticks=%h last=%0d",
               want.kind, want.task_id, want.deadline, want.ticks, want.last);
      $display("  actual   kind=%0d id=%0d deadline=%h ticks=%h last=%0d",
               got.kind, got.task_id, got.deadline, got.ticks, got.last);
    end
  endtask

  always @(posedge clk) begin : check_result
    sched_result_t want;
    sched_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = make_result(kind_t'(out_kind), out_task_id_res, out_task_deadline,
                        out_exec_ticks, out_last);
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.task_id !== want.task_id ||
            got.deadline !== want.deadline || got.ticks !== want.ticks ||
            got.last !== want.last) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (idle_en && $urandom_range(0, 2) == 0) stall_left <= random_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic run_random_events(int count);
    int r;
    logic [ID_BITS-1:0] id;
    logic [TIME_BITS-1:0] dl;
    logic [TIME_BITS-1:0] nw;
    repeat (count) begin
      r  = $urandom_range(0, 99);
      id = ID_BITS'($urandom_range(0, NUM_IDS - 1));
      dl = $urandom;
      nw = $urandom;
      if (r < 35) begin
        if ($urandom_range(0, 4) != 0) id = pick_id(1'b0);
        case ($urandom_range(0, 9))
          0: dl = '0;
          1: dl = '1;
          2: ;
          default: dl = tick_now + $urandom_range(0, 300);
        endcase
        send_event(MODE_INSERT, id, dl, nw, 1'($urandom_range(0, 1)));
      end else if (r < 60) begin
        if ($urandom_range(0, 4) != 0) id = pick_id(1'b1);
        send_event(MODE_REMOVE, id, dl, nw, 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        tick_now = tick_now + $urandom_range(0, 60);
        case ($urandom_range(0, 19))
          0: nw = '0;
          1: nw = '1;
          2, 3: ;
          default: nw = tick_now;
        endcase
        send_event(MODE_TICK, id, dl, nw, 1'($urandom_range(0, 1)));
      end else begin
        send_event(MODE_SCHEDULE, id, dl, nw, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_empty_queue();
    send_event(MODE_SCHEDULE, 4'd9, '1, '1, 1'b1);
    send_event(MODE_TICK, 4'd0, '0, '1, 1'b0);
    send_event(MODE_REMOVE, 4'd3, '0, '0, 1'b0);
  endtask

  // Fills every slot; keys repeat so that equal deadlines must keep arrival order.
  task automatic test_fill_and_order();
    int i;
    send_event(MODE_INSERT, 4'd0, '0, '0, 1'b1);
    for (i = 1; i < NUM_IDS - 1; i++) begin
      send_event(MODE_INSERT, ID_BITS'(i), TIME_BITS'((i % 3) * 50 + 10), $urandom,
                 1'(i % 2));
    end
    send_event(MODE_INSERT, 4'd15, '1, '0, 1'b0);
    send_event(MODE_INSERT, 4'd7, 32'd5, '0, 1'b1);
  endtask

  task automatic test_miss_report();
    send_event(MODE_TICK, 4'd0, '0, '0, 1'b0);
    send_event(MODE_TICK, 4'd0, '0, '1, 1'b0);
    send_event(MODE_REMOVE, 4'd0, '1, '1, 1'b1);
    send_event(MODE_REMOVE, 4'd0, '0, '0, 1'b0);
    send_event(MODE_SCHEDULE, 4'd0, '0, '0, 1'b0);
  endtask

  task automatic test_random_with_gaps();
    run_random_events(60);
  endtask

  task automatic test_random_back_to_back();
    idle_en = 1'b0;
    run_random_events(30);
    idle_en = 1'b1;
  endtask

  // The sender holds off until the queue of expected results has run dry.
  task automatic test_pause_then_resume();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    run_random_events(50);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_INSERT;
    in_task_id    = '0;
    in_deadline   = '0;
    in_now        = '0;
    in_clear_exec = 1'b0;
    out_ready     = 1'b0;
    idle_en       = 1'b1;
    tick_now      = 32'd200;
    q_count       = 0;
    q_present     = '0;
    mismatches    = 0;
    for (int i = 0; i < NUM_IDS; i++) run_ticks[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_fill_and_order();
    test_miss_report();
    test_random_with_gaps();
    test_random_back_to_back();
    test_pause_then_resume();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
